/* sv/tpi_pkg.sv */
// Package for the timed path interpolator: payload structs, codes and state enum.
// No dependencies.
package tpi_pkg;
  localparam int MaxPoints = 256;
  localparam int IdxW = $clog2(MaxPoints);
  localparam int CntW = $clog2(MaxPoints + 1);

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_ADD   = 2'd1,
    OP_END   = 2'd2,
    OP_QUERY = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_RECORDING = 3'd1,
    ST_FEW       = 3'd2,
    ST_NO_SEG    = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef struct packed {
    opcode_t            opcode;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic [31:0]        now_time;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    status_t            status;
    logic [8:0]         point_count;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TOT_RD,
    S_TOT_WT,
    S_MOD,
    S_SCAN_RD,
    S_SCAN_WT,
    S_SCAN_CMP,
    S_DIV,
    S_LERP_RD,
    S_LERP_WT,
    S_LERP_X,
    S_LERP_Y,
    S_DONE
  } state_t;

  typedef struct packed {
    logic        start;
    logic [47:0] dividend;
    logic [31:0] divisor;
  } div_req_t;
endpackage

/* sv/tpi_divider.sv */
// Restoring divider, one quotient bit a cycle, used for both the time wrap and the fraction.
// Depends on tpi_pkg.
module tpi_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  tpi_pkg::div_req_t req,
  output logic              done,
  output logic [47:0]       quotient,
  output logic [31:0]       remainder
);
  import tpi_pkg::*;

  logic [47:0] q_r, q_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] dvs_r, dvs_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [32:0] trial;

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    dvs_nxt = dvs_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial = {rem_r[31:0], q_r[47]};
    if (req.start) begin
      q_nxt = req.dividend;
      rem_nxt = '0;
      dvs_nxt = req.divisor;
      cnt_nxt = 6'd48;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = trial - {1'b0, dvs_r};
        q_nxt = {q_r[46:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[46:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done = done_r;
  assign quotient = q_r;
  assign remainder = rem_r[31:0];

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n) done_r |=> !done_r)
    else $error("divider done held for two cycles");
  a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r != 6'd0) else $error("divider busy with zero count");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("divider done while busy");
endmodule

/* sv/timed_path_interpolator_unit.sv */
// Top level of the timed path interpolator: point memory, sequencer and output register.
// Depends on tpi_pkg and tpi_divider.
//
// Items arrive on in_item and are taken in by a transfer at a rising edge with start high
// and busy low. Each item gives exactly one result, shown on out_item for one cycle while
// out_valid is high; the receiver cannot stall, so out_valid is not held after that
// cycle. Start, add and end items, and queries that are answered at once, go straight
// to S_DONE, which registers out_valid; busy falls only after the result cycle, so a new
// item is taken only once the last one's result has been shown. A full query reads the
// last point time, wraps the playback time with the shared divider, then scans the stored
// segments through the single memory read port, then forms the fraction in the same
// divider and interpolates x and y one multiply a cycle. At zero elapsed time the wrap is
// skipped, and if the last point time is zero the query ends with no segment found.
// busy stays high for the whole of an item, including the result cycle. Synchronous
// active-low reset clears the point count, recording flag and both time origins; the
// point memory is not cleared, since only entries below the point count are ever read.
module timed_path_interpolator_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  tpi_pkg::in_item_t   in_item,
  output logic                out_valid,
  output tpi_pkg::out_item_t  out_item
);
  import tpi_pkg::*;

  // Point memory: one write port, one registered read port.
  logic [63:0] mem [MaxPoints];
  logic        wr_en;
  logic [IdxW-1:0] wr_addr, rd_addr;
  logic [63:0] wr_data, rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[rd_addr];
  end

  state_t state_r, state_nxt;
  in_item_t item_r, item_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic rec_r, rec_nxt;
  logic [31:0] sst_r, sst_nxt, org_r, org_nxt;
  logic [31:0] total_r, total_nxt, t_r, t_nxt;
  logic [CntW-1:0] seg_r, seg_nxt;
  logic [63:0] prev_r, prev_nxt;
  logic        hit_r, hit_nxt;
  logic [63:0] p0_r, p0_nxt, p1_r, p1_nxt;
  logic [31:0] part_r, part_nxt, whole_r, whole_nxt;
  logic [15:0] frac_r, frac_nxt;
  logic signed [23:0] px_r, px_nxt;
  out_item_t out_r, out_nxt;
  logic ov_r, ov_nxt;
  div_req_t dreq;
  logic d_done;
  logic [47:0] d_q;
  logic [31:0] d_rem;
  logic [31:0] trel;
  logic signed [16:0] diff;
  logic signed [34:0] prod;
  logic signed [39:0] lv;
  logic signed [15:0] a_val, b_val;

  tpi_divider u_div (
    .clk(clk), .rst_n(rst_n), .req(dreq),
    .done(d_done), .quotient(d_q), .remainder(d_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      rec_r <= 1'b0;
      sst_r <= '0;
      org_r <= '0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      rec_r <= rec_nxt;
      sst_r <= sst_nxt;
      org_r <= org_nxt;
      ov_r <= ov_nxt;
    end
    item_r <= item_nxt;
    total_r <= total_nxt;
    t_r <= t_nxt;
    seg_r <= seg_nxt;
    prev_r <= prev_nxt;
    hit_r <= hit_nxt;
    p0_r <= p0_nxt;
    p1_r <= p1_nxt;
    part_r <= part_nxt;
    whole_r <= whole_nxt;
    frac_r <= frac_nxt;
    px_r <= px_nxt;
    out_r <= out_nxt;
  end

  // One interpolation multiply, shared between x and y. In S_LERP_X the second point
  // is still in the read register, so x takes it from there.
  always_comb begin
    if (state_r == S_LERP_X) begin
      a_val = p0_r[63:48];
      b_val = rd_data_r[63:48];
    end else begin
      a_val = p0_r[47:32];
      b_val = p1_r[47:32];
    end
    diff = 17'(b_val) - 17'(a_val);
    prod = 35'(diff) * $signed({19'd0, frac_r});
    lv = (40'(a_val) <<< 16) + 40'(prod);
  end

  always_comb begin
    state_nxt = state_r;
    item_nxt = item_r;
    count_nxt = count_r;
    rec_nxt = rec_r;
    sst_nxt = sst_r;
    org_nxt = org_r;
    total_nxt = total_r;
    t_nxt = t_r;
    seg_nxt = seg_r;
    prev_nxt = prev_r;
    hit_nxt = hit_r;
    p0_nxt = p0_r;
    p1_nxt = p1_r;
    part_nxt = part_r;
    whole_nxt = whole_r;
    frac_nxt = frac_r;
    px_nxt = px_r;
    out_nxt = out_r;
    ov_nxt = 1'b0;
    wr_en = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    rd_addr = '0;
    dreq = '0;
    trel = item_r.now_time - org_r;
    case (state_r)
      S_IDLE: begin
        if (start && !busy) begin
          item_nxt = in_item;
          out_nxt = '0;
          out_nxt.point_count = 9'(count_r);
          case (in_item.opcode)
            OP_START: begin
              rec_nxt = 1'b1;
              sst_nxt = in_item.now_time;
              wr_en = 1'b1;
              wr_data = {in_item.coord_x, in_item.coord_y, 32'd0};
              count_nxt = CntW'(1);
              out_nxt.status = ST_RECORDING;
              out_nxt.point_count = 9'd1;
              state_nxt = S_DONE;
            end
            OP_ADD: begin
              if (count_r < CntW'(MaxPoints)) begin
                wr_en = 1'b1;
                wr_addr = count_r[IdxW-1:0];
                wr_data = {in_item.coord_x, in_item.coord_y, in_item.now_time - sst_r};
                count_nxt = count_r + CntW'(1);
                out_nxt.point_count = 9'(count_r + CntW'(1));
                out_nxt.status = rec_r ? ST_RECORDING : ST_OK;
              end else begin
                out_nxt.status = ST_FULL;
              end
              state_nxt = S_DONE;
            end
            OP_END: begin
              rec_nxt = 1'b0;
              org_nxt = in_item.now_time;
              out_nxt.status = ST_OK;
              state_nxt = S_DONE;
            end
            default: begin
              if (rec_r) begin
                out_nxt.status = ST_RECORDING;
                state_nxt = S_DONE;
              end else if (count_r < CntW'(2)) begin
                out_nxt.status = ST_FEW;
                state_nxt = S_DONE;
              end else begin
                out_nxt.status = ST_NO_SEG;
                state_nxt = S_TOT_RD;
              end
            end
          endcase
        end
      end
      S_TOT_RD: begin
        rd_addr = IdxW'(count_r - CntW'(1));
        state_nxt = S_TOT_WT;
      end
      S_TOT_WT: begin
        total_nxt = rd_data_r[31:0];
        if (rd_data_r[31:0] == 32'd0) begin
          state_nxt = S_DONE;
        end else if (trel == 32'd0) begin
          t_nxt = 32'd0;
          seg_nxt = '0;
          hit_nxt = 1'b0;
          state_nxt = S_SCAN_RD;
        end else begin
          dreq.start = 1'b1;
          dreq.dividend = {16'd0, trel - 32'd1};
          dreq.divisor = rd_data_r[31:0];
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        if (d_done) begin
          t_nxt = d_rem + 32'd1;
          seg_nxt = '0;
          hit_nxt = 1'b0;
          state_nxt = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        rd_addr = seg_r[IdxW-1:0];
        state_nxt = S_SCAN_WT;
      end
      S_SCAN_WT: begin
        // The address is held so that the fetched word is still in the read register
        // for the compare. seg_r == 0 fetches the first point; later fetches are
        // segment ends.
        rd_addr = seg_r[IdxW-1:0];
        state_nxt = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (seg_r != '0 && t_r >= prev_r[31:0] && t_r < rd_data_r[31:0]) begin
          hit_nxt = 1'b1;
          p0_nxt = {16'd0, 16'd0, 16'(seg_r - CntW'(1)), 16'd0};
          part_nxt = t_r - prev_r[31:0];
          whole_nxt = rd_data_r[31:0] - prev_r[31:0];
        end
        prev_nxt = rd_data_r;
        if (seg_r == count_r - CntW'(1)) begin
          if (hit_nxt) begin
            dreq.start = 1'b1;
            dreq.dividend = {part_nxt, 16'd0};
            dreq.divisor = whole_nxt;
            state_nxt = S_DIV;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          seg_nxt = seg_r + CntW'(1);
          state_nxt = S_SCAN_RD;
        end
      end
      S_DIV: begin
        if (d_done) begin
          frac_nxt = d_q[15:0];
          seg_nxt = CntW'(p0_r[31:16]);
          state_nxt = S_LERP_RD;
        end
      end
      S_LERP_RD: begin
        rd_addr = seg_r[IdxW-1:0];
        state_nxt = S_LERP_WT;
      end
      S_LERP_WT: begin
        p0_nxt = rd_data_r;
        rd_addr = IdxW'(seg_r + CntW'(1));
        state_nxt = S_LERP_X;
      end
      S_LERP_X: begin
        p1_nxt = rd_data_r;
        state_nxt = S_LERP_Y;
      end
      S_LERP_Y: begin
        if (state_r == S_LERP_Y) begin
          out_nxt.pos_x = px_r;
          out_nxt.pos_y = lv[31:8];
          out_nxt.status = ST_OK;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        ov_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    // x is formed one state ahead of y and kept until the result is assembled.
    if (state_r == S_LERP_X) px_nxt = 24'(lv >>> 8);
  end

  assign busy = (state_r != S_IDLE) || ov_r;
  assign out_valid = ov_r;
  assign out_item = out_r;

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("two results for one item");
  a_busy_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |=> out_valid) else $error("result missing after item");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(MaxPoints)) else $error("point count beyond table");
endmodule

/* test/tpi_checker.sv */
// Checker for the timed path interpolator: watches item and result transfers,
// predicts each result from its own copy of the path table and compares.
// Depends on tpi_pkg.
module tpi_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  tpi_pkg::in_item_t  in_item,
  input  logic               out_valid,
  input  tpi_pkg::out_item_t out_item,
  output int                 fail_count,
  output int                 pending_count
);
  import tpi_pkg::*;

  logic signed [15:0] path_x[MaxPoints];
  logic signed [15:0] path_y[MaxPoints];
  logic [31:0]        path_t[MaxPoints];
  int unsigned        n_points;
  logic               recording;
  logic [31:0]        stroke_origin;
  logic [31:0]        replay_origin;
  out_item_t          expected_ring[8];
  int unsigned        issued;
  int unsigned        checked;

  assign pending_count = int'(issued - checked);

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch on %s: got %0h, expected %0h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  function automatic logic signed [23:0] blend(input logic signed [15:0] a,
                                               input logic signed [15:0] b,
                                               input logic [31:0] frac);
    logic signed [63:0] v;
    v = 64'(signed'(a)) * 65536 + (64'(signed'(b)) - 64'(signed'(a))) * $signed({32'd0, frac});
    return 24'(v >>> 8);  // arithmetic shift is the floor division by 256
  endfunction

  // Applies one item to the local path table and returns the result it yields.
  function automatic out_item_t replay_step(input in_item_t it);
    out_item_t r;
    logic [31:0] total, t, t0, t1, frac;
    logic [63:0] part;
    r = '0;
    r.status = ST_OK;
    case (it.opcode)
      OP_START: begin
        recording = 1'b1;
        stroke_origin = it.now_time;
        path_x[0] = it.coord_x;
        path_y[0] = it.coord_y;
        path_t[0] = '0;
        n_points = 1;
        r.status = ST_RECORDING;
      end
      OP_ADD: begin
        if (n_points < MaxPoints) begin
          path_x[n_points] = it.coord_x;
          path_y[n_points] = it.coord_y;
          path_t[n_points] = it.now_time - stroke_origin;
          n_points++;
          r.status = recording ? ST_RECORDING : ST_OK;
        end else begin
          r.status = ST_FULL;
        end
      end
      OP_END: begin
        recording = 1'b0;
        replay_origin = it.now_time;
      end
      default: begin
        if (recording) begin
          r.status = ST_RECORDING;
        end else if (n_points < 2) begin
          r.status = ST_FEW;
        end else begin
          total = path_t[n_points-1];
          t = it.now_time - replay_origin;
          r.status = ST_NO_SEG;
          if (total != 0) begin
            if (t != 0) t = ((t - 1) % total) + 1;
            for (int i = 0; i + 1 < n_points; i++) begin
              t0 = path_t[i];
              t1 = path_t[i+1];
              if (t >= t0 && t < t1) begin
                part = {32'd0, t - t0} << 16;
                frac = 32'(part / {32'd0, t1 - t0});
                r.pos_x = blend(path_x[i], path_x[i+1], frac);
                r.pos_y = blend(path_y[i], path_y[i+1], frac);
                r.status = ST_OK;
              end
            end
          end
        end
      end
    endcase
    r.point_count = 9'(n_points);
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      n_points <= 0;
      recording <= 1'b0;
      stroke_origin <= '0;
      replay_origin <= '0;
      fail_count <= 0;
      issued <= 0;
      checked <= 0;
    end else begin
      if (out_valid) begin
        if (issued == checked) begin
          report_mismatch("unexpected result", 32'(out_item), 32'd0);
        end else begin
          want = expected_ring[3'(checked)];
          checked++;
          if (out_item.pos_x !== want.pos_x)
            report_mismatch("pos_x", 32'(out_item.pos_x), 32'(want.pos_x));
          if (out_item.pos_y !== want.pos_y)
            report_mismatch("pos_y", 32'(out_item.pos_y), 32'(want.pos_y));
          if (out_item.status !== want.status)
            report_mismatch("status", 32'(out_item.status), 32'(want.status));
          if (out_item.point_count !== want.point_count)
            report_mismatch("point_count", 32'(out_item.point_count),
                            32'(want.point_count));
        end
      end
      if (start && !busy) begin
        expected_ring[3'(issued)] = replay_step(in_item);
        issued++;
      end
    end
  end
endmodule

/* test/tb_timed_path_interpolator_unit.sv */
// Testbench top for the timed path interpolator: drives items with random gaps and
// gives the verdict. Depends on tpi_pkg, timed_path_interpolator_unit and tpi_checker.
module tb_timed_path_interpolator_unit;
  import tpi_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;
  int        fail_count;
  int        pending_count;
  logic [31:0] clock_ms;  // the stimulus notion of absolute time

  timed_path_interpolator_unit i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  tpi_checker i_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offers one item after a random gap and holds it until the transfer takes place.
  // Start stays high after a transfer and is lowered only when a gap follows, so it
  // never receives two assignments within one time step.
  task automatic send_item(input opcode_t op, input logic [15:0] x, input logic [15:0] y,
                           input logic [31:0] stamp);
    int gap;
    gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19));
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_item.opcode   <= op;
    in_item.coord_x  <= x;
    in_item.coord_y  <= y;
    in_item.now_time <= stamp;
    start <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  // Random step of the clock: mostly small, occasionally huge so that wrap is reached.
  function automatic logic [31:0] time_step();
    case ($urandom_range(0, 9))
      0:       return $urandom();
      1:       return 0;
      default: return $urandom_range(1, 200);
    endcase
  endfunction

  // A well-formed stroke of random length, then several queries across its span.
  task automatic record_and_play(input int unsigned len);
    send_item(OP_START, 16'($urandom()), 16'($urandom()), clock_ms);
    for (int i = 1; i < len; i++) begin
      clock_ms += ($urandom_range(0, 7) == 0) ? time_step() : $urandom_range(1, 50);
      send_item(OP_ADD, 16'($urandom()), 16'($urandom()), clock_ms);
    end
    clock_ms += $urandom_range(0, 30);
    send_item(OP_END, 16'($urandom()), 16'($urandom()), clock_ms);
    repeat ($urandom_range(1, 6)) begin
      clock_ms += time_step();
      send_item(OP_QUERY, 16'($urandom()), 16'($urandom()), clock_ms);
    end
  endtask

  initial begin
    int unsigned op;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    clock_ms = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: queries on an empty table, then extreme coordinates and times.
    send_item(OP_QUERY, 16'h0000, 16'h0000, 32'd0);
    send_item(OP_START, 16'h8000, 16'h7fff, 32'hffff_fff0);
    send_item(OP_QUERY, 16'h0000, 16'h0000, 32'd5);        // query while recording
    send_item(OP_END, 16'hffff, 16'hffff, 32'hffff_fff0);
    send_item(OP_QUERY, 16'h0000, 16'h0000, 32'd1);        // only one point
    send_item(OP_START, 16'h8000, 16'h7fff, 32'hffff_fff0);
    send_item(OP_ADD, 16'h7fff, 16'h8000, 32'h0000_0010);  // relative time wraps
    send_item(OP_ADD, 16'h8000, 16'h7fff, 32'h0000_0030);
    send_item(OP_END, 16'h0000, 16'h0000, 32'd100);
    send_item(OP_QUERY, 16'h0000, 16'h0000, 32'd100);      // elapsed time zero
    send_item(OP_QUERY, 16'h0000, 16'h0000, 32'd113);
    send_item(OP_QUERY, 16'h0000, 16'h0000, 32'd132);      // elapsed time equals the second point's time
    send_item(OP_QUERY, 16'h0000, 16'h0000, 32'd99);       // playback time wraps
    send_item(OP_ADD, 16'h1234, 16'hfedc, 32'hffff_fff0);  // add while not recording
    send_item(OP_QUERY, 16'h0000, 16'h0000, 32'd150);      // zero path length
    send_item(OP_START, 16'h0001, 16'h0002, 32'd0);
    send_item(OP_ADD, 16'h0003, 16'h0004, 32'd50);
    send_item(OP_ADD, 16'h0005, 16'h0006, 32'd20);         // times not increasing
    send_item(OP_END, 16'h0000, 16'h0000, 32'd0);
    send_item(OP_QUERY, 16'h0000, 16'h0000, 32'd10);
    send_item(OP_QUERY, 16'h0000, 16'h0000, 32'd30);
    // Fill the table to the brim, overflow it, then restart on the full table.
    send_item(OP_START, 16'h7fff, 16'h8000, 32'd0);
    for (int i = 1; i <= MaxPoints; i++)
      send_item(OP_ADD, 16'($urandom()), 16'($urandom()), 32'(i * 3));
    send_item(OP_END, 16'h0000, 16'h0000, 32'd1000);
    send_item(OP_QUERY, 16'h0000, 16'h0000, 32'd1400);
    send_item(OP_QUERY, 16'h0000, 16'h0000, 32'hffff_ffff);
    send_item(OP_START, 16'h0000, 16'h0000, 32'd7);

    // Random part: mostly well-formed strokes of about ten items each, with some
    // loose items as noise.
    clock_ms = $urandom();
    for (int n = 0; n < 1360; ) begin
      op = $urandom_range(0, 9);
      if (op < 7) begin
        record_and_play(($urandom_range(0, 15) == 0) ? $urandom_range(2, 40)
                                                      : $urandom_range(1, 8));
        n += 10;
      end else begin
        clock_ms += time_step();
        send_item(opcode_t'($urandom_range(0, 3)), 16'($urandom()), 16'($urandom()),
                  clock_ms);
        n++;
      end
    end
    start <= 1'b0;

    // Drain: wait for every expected result, then allow a full query's latency.
    while (pending_count != 0) @(posedge clk);
    repeat (1000) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog: fails the run if the stimulus and drain do not finish.
  initial begin
    #100_000_000;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
